### rtl/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

    localparam int unsigned BlockBits = 512;
    localparam int unsigned WordBits  = 32;
    localparam int unsigned Rounds    = 64;
    localparam int unsigned CountBits = 61;
    localparam int unsigned DigestWords = 8;

    localparam logic [7:0] PadByte   = 8'h80;
    localparam logic [5:0] LenStart  = 6'd56;
    localparam logic [5:0] FillLast  = 6'd63;
    localparam logic [5:0] RoundLast = 6'd63;
    localparam logic [2:0] LastIdx   = 3'd7;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } sha_state_t;

    // source of the byte shifted into the block register
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic      shift_en;
        byte_src_t byte_src;
        logic      count_en;
        logic      load_work;
        logic      round_en;
        logic      add_chain;
        logic      clear_msg;
        logic [2:0] out_idx;
    } sha_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
        logic round_last;
    } sha_stat_t;

    localparam logic [31:0] IvTab [DigestWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KTab [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

### rtl/sha_datapath.sv
`timescale 1ns / 1ps

module sha_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::sha_cmd_t cmd,
    input  logic [7:0]        byte_in,
    output sha_pkg::sha_stat_t stat,
    output logic [31:0]       digest_word
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [511:0] blk_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  count_reg;
    logic [5:0]   round_reg;
    logic [31:0]  work_reg  [8];
    logic [31:0]  work_next [8];
    logic [31:0]  chain_reg [8];

    logic [7:0]  byte_sel;
    logic [63:0] len_bits;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w9;
    logic [31:0] w14;
    logic [31:0] w_new;
    logic [31:0] big_e;
    logic [31:0] big_a;
    logic [31:0] ch;
    logic [31:0] mj;
    logic [31:0] t1;
    logic [31:0] t2;

    assign len_bits = {count_reg, 3'b000};

    always_comb
    begin
        case (cmd.byte_src)
            sha_pkg::SRC_INPUT: byte_sel = byte_in;
            sha_pkg::SRC_PAD80: byte_sel = sha_pkg::PadByte;
            sha_pkg::SRC_ZERO:  byte_sel = 8'h00;
            sha_pkg::SRC_LEN:   byte_sel = len_bits[{~fill_reg[2:0], 3'b000} +: 8];
            default:            byte_sel = 8'h00;
        endcase
    end

    // message schedule window, w[t] sits at the top of the block register
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];

    assign w_new = w0 + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3))
                 + (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

    assign big_e = rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25);
    assign big_a = rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22);
    assign ch    = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign mj    = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]);
    assign t1    = work_reg[7] + big_e + ch + sha_pkg::KTab[round_reg] + w0;
    assign t2    = big_a + mj;

    always_comb
    begin
        work_next[0] = t1 + t2;
        work_next[1] = work_reg[0];
        work_next[2] = work_reg[1];
        work_next[3] = work_reg[2];
        work_next[4] = work_reg[3] + t1;
        work_next[5] = work_reg[4];
        work_next[6] = work_reg[5];
        work_next[7] = work_reg[6];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            blk_reg <= {blk_reg[503:0], byte_sel};
        end
        else if (cmd.round_en)
        begin
            blk_reg <= {blk_reg[479:0], w_new};
        end
        if (cmd.load_work)
        begin
            work_reg <= chain_reg;
        end
        else if (cmd.round_en)
        begin
            work_reg <= work_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_pkg::IvTab[i];
            end
        end
        else
        begin
            if (cmd.clear_msg)
            begin
                fill_reg <= '0;
            end
            else if (cmd.shift_en)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.clear_msg)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_en)
            begin
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.load_work)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_en)
            begin
                round_reg <= round_reg + 6'd1;
            end
            for (int i = 0; i < 8; i++)
            begin
                if (cmd.clear_msg)
                begin
                    chain_reg[i] <= sha_pkg::IvTab[i];
                end
                else if (cmd.add_chain)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
        end
    end

    assign stat.fill_last   = (fill_reg == sha_pkg::FillLast);
    assign stat.fill_at_len = (fill_reg == sha_pkg::LenStart);
    assign stat.round_last  = (round_reg == sha_pkg::RoundLast);

    assign digest_word = chain_reg[cmd.out_idx];

endmodule

### rtl/sha_ctrl.sv
`timescale 1ns / 1ps

module sha_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_byte_valid,
    input  logic               in_last,
    output logic               in_ready,
    output logic               out_valid,
    output logic               out_last,
    input  logic               out_ready,
    input  sha_pkg::sha_stat_t stat,
    output sha_pkg::sha_cmd_t  cmd
);

    sha_pkg::sha_state_t state_reg;
    sha_pkg::sha_state_t state_next;
    sha_pkg::sha_state_t ret_reg;
    sha_pkg::sha_state_t ret_next;
    logic [2:0]          idx_reg;
    logic [2:0]          idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            ret_reg   <= sha_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        idx_next      = idx_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        out_last      = (idx_reg == sha_pkg::LastIdx);
        cmd.shift_en  = 1'b0;
        cmd.byte_src  = sha_pkg::SRC_INPUT;
        cmd.count_en  = 1'b0;
        cmd.load_work = 1'b0;
        cmd.round_en  = 1'b0;
        cmd.add_chain = 1'b0;
        cmd.clear_msg = 1'b0;
        cmd.out_idx   = idx_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.shift_en = in_byte_valid;
                    cmd.count_en = in_byte_valid;
                    if (in_byte_valid && stat.fill_last)
                    begin
                        cmd.load_work = 1'b1;
                        state_next    = sha_pkg::ST_ROUND;
                        ret_next      = in_last ? sha_pkg::ST_PAD80 : sha_pkg::ST_IDLE;
                    end
                    else if (in_last)
                    begin
                        state_next = sha_pkg::ST_PAD80;
                    end
                end
            end
            sha_pkg::ST_PAD80:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = sha_pkg::SRC_PAD80;
                state_next   = sha_pkg::ST_PADZ;
                if (stat.fill_last)
                begin
                    cmd.load_work = 1'b1;
                    state_next    = sha_pkg::ST_ROUND;
                    ret_next      = sha_pkg::ST_PADZ;
                end
            end
            sha_pkg::ST_PADZ:
            begin
                if (stat.fill_at_len)
                begin
                    state_next = sha_pkg::ST_PADLEN;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_src = sha_pkg::SRC_ZERO;
                    if (stat.fill_last)
                    begin
                        cmd.load_work = 1'b1;
                        state_next    = sha_pkg::ST_ROUND;
                        ret_next      = sha_pkg::ST_PADZ;
                    end
                end
            end
            sha_pkg::ST_PADLEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = sha_pkg::SRC_LEN;
                if (stat.fill_last)
                begin
                    cmd.load_work = 1'b1;
                    state_next    = sha_pkg::ST_ROUND;
                    ret_next      = sha_pkg::ST_OUT;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (stat.round_last)
                begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD:
            begin
                cmd.add_chain = 1'b1;
                state_next    = ret_reg;
            end
            sha_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha_pkg::LastIdx)
                    begin
                        cmd.clear_msg = 1'b1;
                        state_next    = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    a_load_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_work |-> (cmd.shift_en && stat.fill_last))
        else $error("compression started without a full block");

    a_round_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND && stat.round_last) |=>
        (state_reg == sha_pkg::ST_FOLD))
        else $error("last round not followed by chain update");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_OUT && out_ready && idx_reg == sha_pkg::LastIdx) |=>
        (state_reg == sha_pkg::ST_IDLE && idx_reg == 3'd0))
        else $error("digest end did not return to idle");
`endif

endmodule

### rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps

// channel   | dir | handshake          | payload
// ----------+-----+--------------------+------------------------------------------
// s (in)    | in  | s_tvalid/s_tready  | s_tdata data_byte, s_tuser byte_valid,
//           |     |                    | s_tlast end_of_message
// m (out)   | out | m_tvalid/m_tready  | m_tdata digest_word, word_index,
//           |     |                    | m_tlast last_word
//
// one beat a cycle while bytes fill the block buffer; every 64th byte starts a
// compression (64 rounds on a single round unit plus the chain update) that
// holds the input off
// end of message: padding bytes go through the same buffer, with one or two
// compressions, then 8 output beats; the input is held off from the end beat
// until the last digest word is taken
// reset clears the chain value to the initial hash and counts to zero
// a stall on the output simply holds the digest word in place

module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast
);

    sha_pkg::sha_cmd_t  cmd;
    sha_pkg::sha_stat_t stat;
    logic [31:0]        digest_word;

    sha_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_byte_valid (s_tuser),
        .in_last       (s_tlast),
        .in_ready      (s_tready),
        .out_valid     (m_tvalid),
        .out_last      (m_tlast),
        .out_ready     (m_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    sha_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .byte_in     (s_tdata),
        .stat        (stat),
        .digest_word (digest_word)
    );

    // word index comes straight from the controller's output counter
    assign m_tdata = {5'b00000, cmd.out_idx, digest_word};

endmodule

### tb/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

    localparam int unsigned RandomBeats = 420;
    localparam int unsigned SettleCycles = 200;
    localparam int unsigned TimeoutNs = 2_000_000;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one expected output beat
    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    // running hash of the current message plus the digest words still owed
    class digest_tracker;
        logic [31:0]  chain [8];
        logic [7:0]   blk [64];
        int unsigned  fill;
        logic [60:0]  nbytes;
        digest_beat_t pending_words [$];
        int unsigned  errors;

        function new();
            errors = 0;
            foreach (blk[i])
                blk[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            foreach (chain[i])
                chain[i] = InitHash[i];
            fill = 0;
            nbytes = '0;
        endfunction

        static function logic [31:0] ror32(logic [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1;
            logic [31:0] t2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = w[i-16] + w[i-7]
                     + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                     + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
            foreach (v[i])
                v[i] = chain[i];
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (chain[i])
                chain[i] = chain[i] + v[i];
        endfunction

        // 0x80, zeros, then the 64-bit bit length; spills into a second block
        // when the length field no longer fits
        function void close_message();
            logic [63:0] bit_len;
            int unsigned pos;
            bit_len = {nbytes, 3'b000};
            blk[fill] = 8'h80;
            pos = fill + 1;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                blk[56 + i] = bit_len[63 - 8*i -: 8];
            compress();
        endfunction

        // accepted input beat
        function void take_beat(logic [7:0] data, logic valid, logic eom);
            digest_beat_t exp_beat;
            if (valid)
            begin
                blk[fill] = data;
                fill = (fill + 1) % 64;
                nbytes = nbytes + 61'd1;
                if (fill == 0)
                    compress();
            end
            if (eom)
            begin
                close_message();
                for (int k = 0; k < 8; k++)
                begin
                    exp_beat.word = chain[k];
                    exp_beat.idx = 3'(k);
                    exp_beat.last = (k == 7);
                    pending_words = {pending_words, exp_beat};
                end
                restart();
            end
        endfunction

        // accepted output beat
        function void check_word(logic [39:0] data, logic last);
            digest_beat_t exp_beat;
            if (pending_words.size() == 0)
            begin
                $error("digest beat with nothing expected: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            exp_beat = pending_words.pop_front();
            if (data[31:0] !== exp_beat.word)
            begin
                $error("digest_word: expected %h, actual %h", exp_beat.word, data[31:0]);
                errors++;
            end
            if (data[34:32] !== exp_beat.idx)
            begin
                $error("word_index: expected %0d, actual %0d", exp_beat.idx, data[34:32]);
                errors++;
            end
            if (last !== exp_beat.last)
            begin
                $error("last_word: expected %b, actual %b", exp_beat.last, last);
                errors++;
            end
            if (data[39:35] !== 5'b0)
            begin
                $error("tdata padding: expected %h, actual %h", 5'b0, data[39:35]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] byte_valid
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] digest_word, [34:32] word_index
    logic        m_tlast;

    // no random idling on either side while set
    logic        calm = 1'b0;
    int unsigned sent_beats = 0;

    digest_tracker digests;

    sha256_stream_hasher uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // output side stalls about 7 percent of the time
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= 7);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            digests.check_word(m_tdata, m_tlast);

    // one input beat; returns right after the edge that accepts it
    task automatic send_beat(input logic [7:0] data, input logic valid, input logic eom);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom);
            s_tuser <= 1'($urandom);
            s_tlast <= 1'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= valid;
        s_tlast <= eom;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        digests.take_beat(data, valid, eom);
        sent_beats++;
    endtask

    // hold the input off until every owed digest word has come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (digests.pending_words.size() != 0)
            @(posedge clk);
    endtask

    // random message; ignored beats sprinkled in, end either on the last
    // byte or on a separate beat with no byte
    task automatic send_message(input int unsigned len, input bit split_end);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 8)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, !split_end && (i == len - 1));
        end
        if (split_end || len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int unsigned len;
        int unsigned pick;
        digests = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // empty message
        send_beat(8'h00, 1'b0, 1'b1);
        // one byte that also ends the message, both byte extremes
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        // "abc" with ignored bytes around it and a byte-less end beat
        send_beat(8'ha5, 1'b0, 1'b0);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b1);
        // byte-less end beat carrying all ones in the ignored data
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        wait_drained();

        // padding just fits, padding needs a second block, exactly one block
        send_message(55, 1'b0);
        send_message(56, 1'b1);
        send_message(64, 1'b0);
        wait_drained();

        while (sent_beats < RandomBeats)
        begin
            calm = (sent_beats >= 220 && sent_beats < 320);
            pick = $urandom_range(9);
            if (pick < 4)
                len = $urandom_range(20);
            else if (pick < 7)
            begin
                case ($urandom_range(9))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = 54;
                    3:       len = 55;
                    4:       len = 56;
                    5:       len = 57;
                    6:       len = 63;
                    7:       len = 64;
                    8:       len = 65;
                    default: len = 119 + $urandom_range(1);
                endcase
            end
            else if (pick < 9)
                len = $urandom_range(70, 21);
            else
                len = $urandom_range(140, 100);
            send_message(len, 1'($urandom_range(1)));
        end
        calm = 1'b0;

        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        if (digests.errors == 0 && digests.pending_words.size() == 0)
            $display("PASS sha256_stream_hasher");
        else
            $display("FAIL sha256_stream_hasher");
        $finish;
    end

    initial
    begin
        #(TimeoutNs);
        $display("FAIL sha256_stream_hasher");
        $finish;
    end

endmodule

### sha256_stream_hasher.f
rtl/sha_pkg.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_stream_hasher.sv
tb/sha256_stream_hasher_tb.sv
